FILE: rtl/per_channel_trimmed_mean_assert.svh
`ifndef PER_CHANNEL_TRIMMED_MEAN_ASSERT_SVH
`define PER_CHANNEL_TRIMMED_MEAN_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCTM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PCTM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pctm_pkg.sv
package pctm_pkg;

  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned AVG_W    = 16;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned CNT_W    = 8;

  localparam logic [CNT_W-1:0] SET_RESET  = 8'd10;
  localparam logic [CNT_W-1:0] SET_LOW    = 8'd1;
  localparam logic [CNT_W-1:0] SET_HIGH   = 8'd253;
  localparam logic [CNT_W:0]   TRIM_EXTRA = 9'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE     = 2'd0,
    OP_SET_ENABLE = 2'd1,
    OP_ENABLE_ALL = 2'd2,
    OP_LOAD_COUNT = 2'd3
  } opcode_e;

endpackage

FILE: rtl/pctm_ram.sv
module pctm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pctm_div.sv
module pctm_div #(
  parameter int unsigned DW = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DW-1:0]                 dividend_i,
  input  logic [pctm_pkg::CNT_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [DW-1:0]                 quotient_o
);

  localparam int unsigned DvW   = pctm_pkg::CNT_W;
  localparam int unsigned StepW = $clog2(DW + 1);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DvW-1:0]   rem_q, rem_d;
  logic [DvW-1:0]   dvs_q, dvs_d;
  logic [DW-1:0]    quo_q, quo_d;
  logic [DvW:0]     rem_sh;
  logic [DvW:0]     rem_sub;
  logic             fits;

  // One quotient bit per cycle, restoring.
  always_comb begin
    rem_sh  = {rem_q, quo_q[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    run_d   = run_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (run_q) begin
      quo_d  = {quo_q[DW-2:0], fits};
      rem_d  = fits ? rem_sub[DvW-1:0] : rem_sh[DvW-1:0];
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/per_channel_trimmed_mean.sv
// Per-channel trimmed-mean averager for ADC samples.
// Command channel: an item transfers on a rising edge with start_i high and
// busy_o low. Opcodes: sample, set one channel's enable, enable all channels,
// load one channel's window setting (saturated into 1..253).
// Result channel: each item gives one result, on the result ports for exactly
// one cycle with done_o high. The receiver cannot hold it off.
// Each item passes the load, calc and write-back states; a sample that closes
// a window also passes the divide state, where the divider makes one quotient
// bit per cycle (16 quotient bits).
// busy_o stays high from the transfer until the result cycle, so no new item
// is taken while one is in progress; the next item may transfer in the
// cycle that shows the previous result.
// Per-channel state lives in one RAM with a registered read port: each item
// reads its entry, updates it and writes it back. Never-written entries read
// as the reset window (setting 10, empty window, average 0) through a row of
// valid bits, so reset takes effect at once, with no clearing pass.
// Enable flags sit in flip-flops and reset to one.
// A channel >= NUM_CHANNELS changes nothing but enable-all and reports zeros.
module per_channel_trimmed_mean #(
  parameter int unsigned NUM_CHANNELS = 32,
  parameter int unsigned SAMPLE_MAX   = 4095
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     opcode_i,
  input  logic [pctm_pkg::CHAN_W-1:0]    channel_i,
  input  logic [pctm_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                           enable_flag_i,
  input  logic [pctm_pkg::CNT_W-1:0]     count_value_i,
  output logic                           done_o,
  output logic [pctm_pkg::CHAN_W-1:0]    channel_out_o,
  output logic [pctm_pkg::AVG_W-1:0]     average_o,
  output logic                           new_average_o,
  output logic                           collecting_o
);

  `include "per_channel_trimmed_mean_assert.svh"

  localparam int unsigned AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SW    = pctm_pkg::SAMPLE_W;
  localparam int unsigned MinW  = $clog2(SAMPLE_MAX + 1);
  localparam int unsigned CmpW  = (MinW > SW) ? MinW : SW;
  localparam int unsigned TW    = CmpW + 1;
  localparam int unsigned MagW  = (TW > pctm_pkg::SUM_W) ? TW : pctm_pkg::SUM_W;
  localparam int unsigned AvgW  = pctm_pkg::AVG_W;
  localparam int unsigned SumW  = pctm_pkg::SUM_W;
  localparam int unsigned CntW  = pctm_pkg::CNT_W;
  localparam int unsigned WordW = AvgW + SumW + CntW + SW + MinW + CntW;
  localparam int unsigned ChW   = pctm_pkg::CHAN_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_CALC = 5'b00100,
    S_DIV  = 5'b01000,
    S_WB   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Accepted command
  pctm_pkg::opcode_e op_q;
  logic [ChW-1:0]    chan_q;
  logic [AW-1:0]     addr_q;
  logic [SW-1:0]     smp_q;
  logic              flag_q;
  logic [CntW-1:0]   cnt_q;
  logic              rng_q;

  // Working copy of the entry
  logic [AvgW-1:0] avg_q, avg_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0] num_q, num_d;
  logic [SW-1:0]   max_q, max_d;
  logic [MinW-1:0] min_q, min_d;
  logic [CntW-1:0] set_q, set_d;
  logic            win_q, win_d;
  logic            neg_q, neg_d;

  logic [NUM_CHANNELS-1:0] vld_q;
  logic [NUM_CHANNELS-1:0] enable_q;

  logic [ChW-1:0]  chan_out_q;
  logic [AvgW-1:0] avg_out_q;
  logic            new_out_q;
  logic            coll_out_q;
  logic            done_q;

  logic            accept;
  logic            in_rng;
  logic [CntW-1:0] cnt_sat;
  logic [WordW-1:0] rdata;
  logic [WordW-1:0] wdata;
  logic            ram_we;

  // Entry fields as read, with unwritten entries mapped to reset values
  logic [AvgW-1:0] r_avg;
  logic [SumW-1:0] r_sum;
  logic [CntW-1:0] r_num;
  logic [SW-1:0]   r_max;
  logic [MinW-1:0] r_min;
  logic [CntW-1:0] r_set;

  logic [CntW-1:0] num_inc;
  logic [TW-1:0]   trim;
  logic [MagW-1:0] sum_ext;
  logic [MagW-1:0] trim_ext;
  logic            div_start;
  logic            div_done;
  logic [MagW-1:0] div_mag;
  logic [MagW-1:0] div_quot;
  logic [AvgW-1:0] quot_lo;
  logic            coll_now;

  logic            in_div;
  logic            in_wb;
  logic            out_hi;
  logic            out_zero;

  assign accept = start_i && (state_q == S_IDLE);
  assign in_rng = ({2'b00, channel_i} < 7'(NUM_CHANNELS));

  always_comb begin
    cnt_sat = count_value_i;
    if (count_value_i < pctm_pkg::SET_LOW) begin
      cnt_sat = pctm_pkg::SET_LOW;
    end else if (count_value_i > pctm_pkg::SET_HIGH) begin
      cnt_sat = pctm_pkg::SET_HIGH;
    end
  end

  pctm_ram #(
    .WIDTH (WordW),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (AW'(channel_i)),
    .rdata_o (rdata)
  );

  assign ram_we = (state_q == S_WB) && rng_q;
  assign wdata  = {avg_q, sum_q, num_q, max_q, min_q, set_q};

  always_comb begin
    if (vld_q[addr_q]) begin
      {r_avg, r_sum, r_num, r_max, r_min, r_set} = rdata;
    end else begin
      r_avg = '0;
      r_sum = '0;
      r_num = '0;
      r_max = '0;
      r_min = MinW'(SAMPLE_MAX);
      r_set = pctm_pkg::SET_RESET;
    end
  end

  assign num_inc  = r_num + CntW'(1);
  assign trim     = TW'(max_q) + TW'(min_q);
  assign sum_ext  = MagW'(sum_q);
  assign trim_ext = MagW'(trim);
  assign quot_lo  = div_quot[AvgW-1:0];
  assign coll_now = enable_q[addr_q];

  pctm_div #(
    .DW (MagW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag),
    .divisor_i  (set_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    avg_d     = avg_q;
    sum_d     = sum_q;
    num_d     = num_q;
    max_d     = max_q;
    min_d     = min_q;
    set_d     = set_q;
    win_d     = win_q;
    neg_d     = neg_q;
    div_start = 1'b0;
    div_mag   = (sum_ext >= trim_ext) ? (sum_ext - trim_ext) : (trim_ext - sum_ext);
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        avg_d = r_avg;
        sum_d = r_sum;
        num_d = r_num;
        max_d = r_max;
        min_d = r_min;
        set_d = r_set;
        win_d = 1'b0;
        if (rng_q && (op_q == pctm_pkg::OP_SAMPLE)) begin
          if (coll_now) begin
            if (smp_q > r_max) begin
              max_d = smp_q;
            end
            if (CmpW'(smp_q) < CmpW'(r_min)) begin
              min_d = MinW'(smp_q);
            end
            sum_d = r_sum + SumW'(smp_q);
            num_d = num_inc;
            win_d = ({1'b0, num_inc} >= ({1'b0, r_set} + pctm_pkg::TRIM_EXTRA));
          end else begin
            sum_d = '0;
            num_d = '0;
            max_d = '0;
            min_d = MinW'(SAMPLE_MAX);
          end
        end else if (rng_q && (op_q == pctm_pkg::OP_LOAD_COUNT)) begin
          set_d = cnt_q;
        end
        state_d = S_CALC;
      end
      S_CALC: begin
        if (win_q) begin
          neg_d     = (sum_ext < trim_ext);
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_d   = neg_q ? (AvgW'(0) - quot_lo) : quot_lo;
          sum_d   = '0;
          num_d   = '0;
          max_d   = '0;
          min_d   = MinW'(SAMPLE_MAX);
          state_d = S_WB;
        end
      end
      S_WB: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      vld_q    <= '0;
      enable_q <= '1;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_WB);
      if (ram_we) begin
        vld_q[addr_q] <= 1'b1;
      end
      if (state_q == S_WB) begin
        if (op_q == pctm_pkg::OP_ENABLE_ALL) begin
          enable_q <= '1;
        end else if (rng_q && (op_q == pctm_pkg::OP_SET_ENABLE)) begin
          enable_q[addr_q] <= flag_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= pctm_pkg::opcode_e'(opcode_i);
      chan_q <= channel_i;
      addr_q <= AW'(channel_i);
      smp_q  <= sample_i;
      flag_q <= enable_flag_i;
      cnt_q  <= cnt_sat;
      rng_q  <= in_rng;
    end
    avg_q <= avg_d;
    sum_q <= sum_d;
    num_q <= num_d;
    max_q <= max_d;
    min_q <= min_d;
    set_q <= set_d;
    win_q <= win_d;
    neg_q <= neg_d;
    // Capture the result on write-back; it shows for one cycle.
    if (state_q == S_WB) begin
      chan_out_q <= chan_q;
      avg_out_q  <= rng_q ? avg_q : '0;
      new_out_q  <= win_q;
      if (!rng_q) begin
        coll_out_q <= 1'b0;
      end else if (op_q == pctm_pkg::OP_ENABLE_ALL) begin
        coll_out_q <= 1'b1;
      end else if (op_q == pctm_pkg::OP_SET_ENABLE) begin
        coll_out_q <= flag_q;
      end else begin
        coll_out_q <= coll_now;
      end
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign channel_out_o = chan_out_q;
  assign average_o     = avg_out_q;
  assign new_average_o = done_q && new_out_q;
  assign collecting_o  = coll_out_q;

  assign in_div   = (state_q == S_DIV);
  assign in_wb    = (state_q == S_WB);
  assign out_hi   = ({2'b00, channel_out_o} >= 7'(NUM_CHANNELS));
  assign out_zero = (average_o == '0) && !collecting_o && !new_average_o;

  `PCTM_ASSERT_NOW(a_done_idle, done_o, !busy_o, "result shown while busy")
  `PCTM_ASSERT_NOW(a_div_in_div, div_done, in_div, "divider done outside divide")
  `PCTM_ASSERT_NEXT(a_div_to_wb, in_div && div_done, in_wb && win_q, "no write-back after divide")
  `PCTM_ASSERT_NOW(a_out_range, done_o && out_hi, out_zero, "out-of-range channel reported state")

endmodule
